// ===== rtl/core/cbms_pkg.sv =====
// Package for the battery monitor supervisor: frame identifiers, register
// indexes and the request and result structs.
// Depends on nothing; used by can_battery_monitor_supervisor_unit.
package cbms_pkg;

    localparam logic [28:0] ID_FAULT     = 29'h0000303;
    localparam logic [28:0] ID_HEARTBEAT = 29'h18EEFF80;
    localparam logic [28:0] ID_TEMP      = 29'h1839F380;
    localparam logic [28:0] ID_MOTOR     = 29'h0000181;

    localparam logic [7:0] REG_NMAX  = 8'hC8;
    localparam logic [7:0] REG_SPEED = 8'h30;

    localparam logic [3:0] MOTOR_MIN_LEN = 4'd3;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HB_TIMEOUT   = 2'd0,
        CFG_TEMP_TIMEOUT = 2'd1,
        CFG_OT_LIMIT     = 2'd2,
        CFG_OT_HOLD      = 2'd3
    } t_cfg_index;

    localparam logic [15:0] RST_HB_TIMEOUT   = 16'd600;
    localparam logic [15:0] RST_TEMP_TIMEOUT = 16'd300;
    localparam logic [7:0]  RST_OT_LIMIT     = 8'd60;
    localparam logic [19:0] RST_OT_HOLD      = 20'd10000;

    // speed full scale is 2^15 - 1
    localparam int          SPEED_SHIFT = 15;
    localparam logic [16:0] SPEED_FULL  = 17'd32767;
    localparam logic [16:0] SPEED_FULL2 = 17'd65534;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [28:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         fault_number;
        logic [7:0]         max_temperature;
        logic signed [15:0] motor_rpm;
        logic               heartbeat_timed_out;
        logic               temp_frame_timed_out;
        logic               overtemp_fault;
        logic               max_speed_known;
    } t_out_item;

endpackage

// ===== rtl/core/can_battery_monitor_supervisor_unit.sv =====
// Top level of the battery monitor supervisor: request register, state
// update, speed scaling stage and result register.
// Depends on cbms_pkg.

// Takes one request per cycle, frame or tick. A frame updates state and gives
// no result; a tick gives one status result, from the request register through
// the next stage to the result register. The request register feeds the state
// update and a 16 by 16 magnitude multiplier for speed samples; the next stage
// divides the product by 32767 with an add and compare and writes the rpm; the
// last register holds the result. Stages that hold no tick move on while the
// result register waits, so requests keep flowing until a stalled tick blocks.
module can_battery_monitor_supervisor_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  cbms_pkg::t_in_item                     i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output cbms_pkg::t_out_item                    o_out,
    input  logic                                   i_cfg_we,
    input  logic [cbms_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cbms_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cbms_pkg::*;

    // configuration
    logic [15:0] r_hb_timeout;
    logic [15:0] r_temp_timeout;
    logic [7:0]  r_ot_limit;
    logic [19:0] r_ot_hold;

    // supervisor state
    logic [4:0]         r_fault, n_fault;
    logic [7:0]         r_max_temp, n_max_temp;
    logic [31:0]        r_hb_seen, n_hb_seen;
    logic [31:0]        r_temp_seen, n_temp_seen;
    logic [31:0]        r_ot_since, n_ot_since;
    logic               r_ot_flag, n_ot_flag;
    logic signed [15:0] r_nmax, n_nmax;
    logic               r_known, n_known;
    logic signed [16:0] r_rpm, n_rpm;
    logic               r_hb_to, n_hb_to;
    logic               r_tf_to, n_tf_to;

    // pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_s1_valid;
    logic      r_s1_tick;
    t_out_item r_s1_stat;
    logic      r_s1_prod_valid;
    logic      r_s1_neg;
    logic [30:0] r_s1_prod;
    logic      r_out_valid;
    t_out_item r_out;

    logic take_out, s1_go, s1_free, s0_go, s0_free;

    logic [31:0]        w_word;
    logic [4:0]         w_enc;
    logic               w_enc_hit;
    logic signed [15:0] w_val;
    logic [15:0]        w_val_mag, w_nmax_mag;
    logic               w_prod_valid;
    t_out_item          w_stat;
    t_out_item          w_out;
    logic [31:0]        w_since_eff;

    logic [15:0] w_quo_hi;
    logic [16:0] w_rem_sum;
    logic [16:0] w_quo;
    logic [16:0] w_corr;

    assign take_out = !r_out_valid || !i_out_stall;
    assign s1_go    = r_s1_valid && (!r_s1_tick || take_out);
    assign s1_free  = !r_s1_valid || s1_go;
    assign s0_go    = r_in_valid && s1_free;
    assign s0_free  = !r_in_valid || s0_go;

    assign o_in_stall  = !s0_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // fault word priority encode, bit 31 highest
    always_comb begin
        w_word    = {r_in.byte0, r_in.byte1, r_in.byte2, r_in.byte3};
        w_enc     = '0;
        w_enc_hit = 1'b0;
        for (int b = 4; b < 32; b++) begin
            if (w_word[b]) begin
                w_enc     = 5'(32 - b);
                w_enc_hit = 1'b1;
            end
        end
    end

    assign w_val      = $signed({r_in.byte2, r_in.byte1});
    assign w_val_mag  = w_val[15] ? 16'(-w_val) : w_val;
    assign w_nmax_mag = r_nmax[15] ? 16'(-r_nmax) : r_nmax;
    assign w_since_eff = (r_ot_since == '0) ? r_in.now_ms : r_ot_since;

    // state update for the request in the input register
    always_comb begin
        n_fault      = r_fault;
        n_max_temp   = r_max_temp;
        n_hb_seen    = r_hb_seen;
        n_temp_seen  = r_temp_seen;
        n_ot_since   = r_ot_since;
        n_ot_flag    = r_ot_flag;
        n_nmax       = r_nmax;
        n_known      = r_known;
        n_hb_to      = r_hb_to;
        n_tf_to      = r_tf_to;
        w_prod_valid = 1'b0;
        if (s0_go) begin
            if (r_in.op == OP_FRAME) begin
                if (r_in.frame_id == ID_FAULT) begin
                    if (w_word == '0) begin
                        n_fault = '0;
                    end else if (w_enc_hit) begin
                        n_fault = w_enc;
                    end
                end
                if (r_in.frame_id == ID_HEARTBEAT) begin
                    n_hb_seen = r_in.now_ms;
                end
                if (r_in.frame_id == ID_TEMP) begin
                    n_temp_seen = r_in.now_ms;
                    n_max_temp  = r_in.byte2;
                end
                if (r_in.frame_id == ID_MOTOR && r_in.frame_len >= MOTOR_MIN_LEN) begin
                    if (r_in.byte0 == REG_NMAX) begin
                        n_nmax  = w_val;
                        n_known = 1'b1;
                    end else if (r_in.byte0 == REG_SPEED) begin
                        w_prod_valid = r_known && (r_nmax != '0);
                    end
                end
            end else begin
                n_hb_to = (r_in.now_ms - r_hb_seen) > {16'd0, r_hb_timeout};
                n_tf_to = (r_in.now_ms - r_temp_seen) > {16'd0, r_temp_timeout};
                if (r_max_temp > r_ot_limit) begin
                    n_ot_since = w_since_eff;
                    if ((r_in.now_ms - w_since_eff) > {12'd0, r_ot_hold}) begin
                        n_ot_flag = 1'b1;
                    end
                end else begin
                    n_ot_since = '0;
                    n_ot_flag  = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_stat                      = '0;
        w_stat.fault_number         = n_fault;
        w_stat.max_temperature      = n_max_temp;
        w_stat.heartbeat_timed_out  = n_hb_to;
        w_stat.temp_frame_timed_out = n_tf_to;
        w_stat.overtemp_fault       = n_ot_flag;
        w_stat.max_speed_known      = n_known;
    end

    always_comb begin
        w_out           = r_s1_stat;
        w_out.motor_rpm = r_rpm[15:0];
    end

    // divide the product magnitude by 2^15 - 1: q = hi + (hi + lo) / (2^15 - 1)
    always_comb begin
        w_quo_hi  = r_s1_prod[30:15];
        w_rem_sum = {1'b0, w_quo_hi} + {2'b00, r_s1_prod[SPEED_SHIFT-1:0]};
        if (w_rem_sum >= SPEED_FULL2) begin
            w_corr = 17'd2;
        end else if (w_rem_sum >= SPEED_FULL) begin
            w_corr = 17'd1;
        end else begin
            w_corr = 17'd0;
        end
        w_quo = {1'b0, w_quo_hi} + w_corr;
        n_rpm = r_rpm;
        if (s1_go && r_s1_prod_valid) begin
            n_rpm = r_s1_neg ? $signed(17'(-w_quo)) : $signed(w_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_timeout   <= RST_HB_TIMEOUT;
            r_temp_timeout <= RST_TEMP_TIMEOUT;
            r_ot_limit     <= RST_OT_LIMIT;
            r_ot_hold      <= RST_OT_HOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HB_TIMEOUT:   r_hb_timeout   <= i_cfg_data[15:0];
                CFG_TEMP_TIMEOUT: r_temp_timeout <= i_cfg_data[15:0];
                CFG_OT_LIMIT:     r_ot_limit     <= i_cfg_data[7:0];
                CFG_OT_HOLD:      r_ot_hold      <= i_cfg_data[19:0];
                default:          r_ot_hold      <= r_ot_hold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= '0;
            r_max_temp  <= '0;
            r_hb_seen   <= '0;
            r_temp_seen <= '0;
            r_ot_since  <= '0;
            r_ot_flag   <= 1'b0;
            r_nmax      <= '0;
            r_known     <= 1'b0;
            r_rpm       <= '0;
            r_hb_to     <= 1'b0;
            r_tf_to     <= 1'b0;
        end else begin
            r_fault     <= n_fault;
            r_max_temp  <= n_max_temp;
            r_hb_seen   <= n_hb_seen;
            r_temp_seen <= n_temp_seen;
            r_ot_since  <= n_ot_since;
            r_ot_flag   <= n_ot_flag;
            r_nmax      <= n_nmax;
            r_known     <= n_known;
            r_rpm       <= n_rpm;
            r_hb_to     <= n_hb_to;
            r_tf_to     <= n_tf_to;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_s1_prod_valid <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (s0_free) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_free) begin
                r_s1_valid      <= s0_go;
                r_s1_prod_valid <= w_prod_valid;
            end
            if (take_out) begin
                r_out_valid <= s1_go && r_s1_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_free && i_in_valid) begin
            r_in <= i_in;
        end
        if (s0_go) begin
            r_s1_tick <= (r_in.op == OP_TICK);
            r_s1_stat <= w_stat;
            r_s1_neg  <= w_val[15] ^ r_nmax[15];
            r_s1_prod <= 31'(w_val_mag * w_nmax_mag);
        end
        if (take_out && s1_go && r_s1_tick) begin
            r_out <= w_out;
        end
    end

    a_fault_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault <= 5'd28)
        else $error("fault number out of range");

    a_ot_flag_since: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ot_flag |-> (r_ot_since != '0))
        else $error("overtemp fault set with idle hold timer");

    a_prod_needs_nmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_prod_valid) |-> (r_known && !r_s1_tick))
        else $error("speed scaling issued without known maximum speed");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_tick))
        else $error("result loaded without a tick");

endmodule
